FILE: rtl/core/pica_pkg.sv
// Shared types, codes and saturation helpers for the PI controller block.
package pica_pkg;

   localparam int DataWidth = 32;
   localparam int CsrIndexWidth = 3;
   localparam int QShift = 16;

   typedef logic signed [DataWidth-1:0] q16_type;

   localparam q16_type Q16Max = 32'sh7FFF_FFFF;
   localparam q16_type Q16Min = 32'sh8000_0000;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic [1:0] STATUS_WITHIN = 2'd0;
   localparam logic [1:0] STATUS_HIGH   = 2'd1;
   localparam logic [1:0] STATUS_LOW    = 2'd2;

   localparam logic [CsrIndexWidth-1:0] CSR_KP      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KI_DT   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_OUT_MIN = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_OUT_MAX = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_INT_MIN = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_INT_MAX = 3'd5;

   typedef struct packed {
      q16_type kp;
      q16_type ki_dt;
      q16_type out_min;
      q16_type out_max;
      q16_type int_min;
      q16_type int_max;
   } cfg_type;

   // product stage -> integrator stage
   typedef struct packed {
      logic    valid;
      logic    opcode;
      logic    err_neg;
      logic    err_pos;
      q16_type pterm;
      q16_type iterm;
   } mid_type;

   function automatic q16_type sat33(input logic signed [DataWidth:0] v);
      q16_type r;
      if (v[DataWidth] != v[DataWidth-1]) begin
         r = v[DataWidth] ? Q16Min : Q16Max;
      end else begin
         r = v[DataWidth-1:0];
      end
      return r;
   endfunction

   function automatic q16_type add_sat(input q16_type a, input q16_type b);
      logic signed [DataWidth:0] s;
      s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
      return sat33(s);
   endfunction

   // upper limit checked first, as the spec requires when min > max
   function automatic q16_type clamp(input q16_type v, input q16_type lo, input q16_type hi);
      q16_type r;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/pica_csr.sv
// Configuration register file: gains and limits.
module pica_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [pica_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [pica_pkg::DataWidth-1:0]       csr_data,
   output pica_pkg::cfg_type                    cfg
);
   import pica_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_KP:      cfg_in.kp      = csr_data;
            CSR_KI_DT:   cfg_in.ki_dt   = csr_data;
            CSR_OUT_MIN: cfg_in.out_min = csr_data;
            CSR_OUT_MAX: cfg_in.out_max = csr_data;
            CSR_INT_MIN: cfg_in.int_min = csr_data;
            CSR_INT_MAX: cfg_in.int_max = csr_data;
            default: ;   // unused indexes are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp      <= '0;
         cfg_ff.ki_dt   <= '0;
         cfg_ff.out_min <= -32'sd65536;
         cfg_ff.out_max <= 32'sd65536;
         cfg_ff.int_min <= -32'sd65536;
         cfg_ff.int_max <= 32'sd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/pica_qmul.sv
// Q16.16 multiply: full product, floor shift, saturate to 32 bits.
module pica_qmul (
   input  pica_pkg::q16_type a,
   input  pica_pkg::q16_type b,
   output pica_pkg::q16_type p
);
   import pica_pkg::*;

   logic signed [2*DataWidth-1:0] prod;
   logic signed [2*DataWidth-1:0] shifted;

   always_comb begin
      prod    = a * b;
      shifted = prod >>> QShift;
      // fits when bits above the sign position all match
      if (shifted[2*DataWidth-1:DataWidth-1] == '0 ||
          shifted[2*DataWidth-1:DataWidth-1] == '1) begin
         p = shifted[DataWidth-1:0];
      end else begin
         p = shifted[2*DataWidth-1] ? Q16Min : Q16Max;
      end
   end

endmodule

FILE: rtl/core/pica_integrator.sv
// Final stage: integral update with anti-windup, output clamp and result register.
module pica_integrator (
   input  logic                clock,
   input  logic                reset,
   input  pica_pkg::cfg_type   cfg,
   input  pica_pkg::mid_type   mid,
   output logic                mid_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pica_pkg::q16_type   rsp_drive_value,
   output logic [1:0]          rsp_limit_status
);
   import pica_pkg::*;

   q16_type    integral_ff, integral_in;
   logic       valid_ff, valid_in;
   q16_type    drive_ff, drive_in;
   logic [1:0] status_ff, status_in;

   q16_type cand;
   q16_type psum;
   logic    take_cand;
   logic    out_ready;
   logic    consume;

   assign out_ready = !valid_ff || !rsp_stall;
   // a clear leaves no result, so it never waits on the output register
   assign mid_ready = !mid.valid || (mid.opcode == OP_CLEAR) || out_ready;
   assign consume   = mid.valid && mid_ready;

   always_comb begin
      cand = clamp(add_sat(integral_ff, mid.iterm), cfg.int_min, cfg.int_max);
      psum = add_sat(mid.pterm, cand);
      if (psum > cfg.out_max) begin
         drive_in  = cfg.out_max;
         status_in = STATUS_HIGH;
         take_cand = mid.err_neg;
      end else if (psum < cfg.out_min) begin
         drive_in  = cfg.out_min;
         status_in = STATUS_LOW;
         take_cand = mid.err_pos;
      end else begin
         drive_in  = psum;
         status_in = STATUS_WITHIN;
         take_cand = 1'b1;
      end

      integral_in = integral_ff;
      valid_in    = valid_ff && rsp_stall;
      if (consume) begin
         if (mid.opcode == OP_CLEAR) begin
            integral_in = '0;
         end else begin
            valid_in = 1'b1;
            if (take_cand) begin
               integral_in = cand;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         integral_ff <= integral_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && mid.opcode == OP_UPDATE) begin
         drive_ff  <= drive_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_drive_value  = drive_ff;
   assign rsp_limit_status = status_ff;

endmodule

FILE: rtl/core/pi_controller_anti_windup_top.sv
// Top level of the PI controller with conditional-integration anti-windup.
//
// Usage:
//   Requests (req_opcode, req_error_value) enter on req_valid/req_stall.
//   An update request yields one response on rsp_valid/rsp_stall carrying
//   the clamped drive value and its limit status; a clear request zeroes
//   the integral and yields no response.
//   Gains and limits are written through csr_write/csr_index/csr_data
//   while the block is idle; indexes 6 and 7 are ignored.
// Timing:
//   Three-stage pipeline: request register, product register (both
//   Q16.16 multiplies in parallel), then integral/clamp stage into the
//   response register. Throughput is one request per cycle while the
//   response is not stalled; the integral feedback loop is closed
//   within the last stage.
// Stall and reset:
//   Each stage advances whenever the next one is empty or draining, so
//   requests keep entering while a response waits; req_stall rises only
//   when all stages are full behind a stalled response.
//   Synchronous reset empties the pipeline, zeroes the integral and loads
//   the register defaults (gains 0, limits +/-1.0).
module pi_controller_anti_windup_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [pica_pkg::DataWidth-1:0]     req_error_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pica_pkg::DataWidth-1:0]     rsp_drive_value,
   output logic [1:0]                         rsp_limit_status,
   input  logic                               csr_write,
   input  logic [pica_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [pica_pkg::DataWidth-1:0]     csr_data
);
   import pica_pkg::*;

   cfg_type cfg;

   logic    s1_valid_ff, s1_valid_in;
   logic    s1_opcode_ff;
   q16_type s1_err_ff;
   logic    s1_ready;

   mid_type mid_ff, mid_in;
   logic    mid_ready;
   logic    s2_ready;

   q16_type pterm;
   q16_type iterm;
   q16_type drive_value;

   pica_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // request stage
   assign s2_ready  = !mid_ff.valid || mid_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_opcode_ff <= req_opcode;
         s1_err_ff    <= req_error_value;
      end
   end

   // product stage
   pica_qmul u_pmul (
      .a (cfg.kp),
      .b (s1_err_ff),
      .p (pterm)
   );

   pica_qmul u_imul (
      .a (cfg.ki_dt),
      .b (s1_err_ff),
      .p (iterm)
   );

   always_comb begin
      mid_in = mid_ff;
      if (s2_ready) begin
         mid_in.valid   = s1_valid_ff;
         mid_in.opcode  = s1_opcode_ff;
         mid_in.err_neg = s1_err_ff < 0;
         mid_in.err_pos = s1_err_ff > 0;
         mid_in.pterm   = pterm;
         mid_in.iterm   = iterm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid <= 1'b0;
      end else begin
         mid_ff.valid <= mid_in.valid;
      end
      mid_ff.opcode  <= mid_in.opcode;
      mid_ff.err_neg <= mid_in.err_neg;
      mid_ff.err_pos <= mid_in.err_pos;
      mid_ff.pterm   <= mid_in.pterm;
      mid_ff.iterm   <= mid_in.iterm;
   end

   // integral and output stage
   pica_integrator u_integrator (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .mid              (mid_ff),
      .mid_ready        (mid_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_drive_value  (drive_value),
      .rsp_limit_status (rsp_limit_status)
   );

   assign rsp_drive_value = drive_value;

endmodule

FILE: rtl/core/pica_checker.sv
// Port-level checker for the PI controller top, attached by bind.
module pica_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [pica_pkg::DataWidth-1:0] rsp_drive_value,
   input logic [1:0]                     rsp_limit_status
);
   import pica_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive_value)
                                 && $stable(rsp_limit_status))
      else $error("stalled response changed");

   // status code three is never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_limit_status != 2'd3)
      else $error("bad limit status");

   // after reset no response is valid
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // requests are only held off when the pipeline is full behind a stall
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without backpressure");

   // a stalled request stays offered
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("stalled request withdrawn");

endmodule

bind pi_controller_anti_windup_top pica_checker u_pica_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_drive_value  (rsp_drive_value),
   .rsp_limit_status (rsp_limit_status)
);
